// ===== hw/rtl/bltd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bltd_pkg
// Shared types, codes and constants of the backlight thermal derate dimmer.
// ----------------------------------------------------------------------------
package bltd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int AVG_DEPTH   = 16;
    localparam int RING_AW     = $clog2(AVG_DEPTH);
    localparam int SUM_W       = SAMPLE_BITS + RING_AW;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OQ_DEPTH    = 4;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_DIM    = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BURN   = 2'd1,
        MODE_BOIL   = 2'd2,
        MODE_SCORCH = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_ENTER_BURN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_BOIL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_SCORCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_UNIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_PERIOD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_PROTECT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_TICK = 3'd7;

    localparam logic [7:0] SW_FADE = 8'd1;
    localparam logic [7:0] SW_RAMP = 8'd2;

    localparam logic [6:0] LIMIT_FULL = 7'd100;
    localparam logic [6:0] LIMIT_BURN = 7'd60;
    localparam logic [6:0] LIMIT_HOT  = 7'd20;
    localparam logic [6:0] RAMP_STEP  = 7'd4;

    typedef struct packed {
        t_cmd                   cmd;
        logic [SAMPLE_BITS-1:0] temp_sample;
        logic [7:0]             backlight_switch;
        logic [7:0]             brightness_target;
    } t_item;

    typedef struct packed {
        logic [15:0] duty;
        logic        pwm_enabled;
        logic [1:0]  thermal_mode;
        logic        derating_active;
        logic [6:0]  brightness_limit;
        logic        derate_report;
        logic [6:0]  brightness_now;
    } t_result;

    typedef struct packed {
        logic                   en;
        logic [RING_AW-1:0]     addr;
        logic [SAMPLE_BITS-1:0] data;
    } t_ring_wr;

endpackage
`default_nettype wire

// ===== hw/rtl/bltd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bltd_in_if
// Input channel: command items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bltd_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       cmd;
    logic [bltd_pkg::SAMPLE_BITS-1:0] temp_sample;
    logic [7:0]                       backlight_switch;
    logic [7:0]                       brightness_target;

    modport source (
        output valid, cmd, temp_sample, backlight_switch, brightness_target,
        input  ready
    );
    modport sink (
        input  valid, cmd, temp_sample, backlight_switch, brightness_target,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/bltd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bltd_out_if
// Output channel: one status result per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bltd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty;
    logic        pwm_enabled;
    logic [1:0]  thermal_mode;
    logic        derating_active;
    logic [6:0]  brightness_limit;
    logic        derate_report;
    logic [6:0]  brightness_now;

    modport source (
        output valid, duty, pwm_enabled, thermal_mode, derating_active,
               brightness_limit, derate_report, brightness_now,
        input  ready
    );
    modport sink (
        input  valid, duty, pwm_enabled, thermal_mode, derating_active,
               brightness_limit, derate_report, brightness_now,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/backlight_thermal_derate_dimmer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// backlight_thermal_derate_dimmer
// Backlight PWM dimmer with thermally derated brightness limit.
// ----------------------------------------------------------------------------
// One transaction per clock is sustained while input ready is high. Inside:
// on acceptance of a sample item the oldest sample is read from the 16-entry ring
// RAM; in the next cycle the running sum, mode machine, dimming and duty are updated,
// the new sample is written back and the result enters a four-entry output queue.
// Input ready stays high while fewer than four transactions are in flight, so
// a waiting result does not stop new items. Entries of the ring not yet
// written read as zero through a fill flag; there is no clearing pass.
// ----------------------------------------------------------------------------
module backlight_thermal_derate_dimmer #(
    parameter int OQ_DEPTH = bltd_pkg::OQ_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    bltd_in_if.sink                                 i_in,
    bltd_out_if.source                              o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [bltd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bltd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(OQ_DEPTH + 1);

    logic                             accept;
    logic                             r_s1_valid;
    bltd_pkg::t_item                  r_s1_item;
    bltd_pkg::t_item                  in_item;
    bltd_pkg::t_ring_wr               ring_wr;
    logic [bltd_pkg::RING_AW-1:0]     ring_idx;
    logic [bltd_pkg::SAMPLE_BITS-1:0] ring_old;
    bltd_pkg::t_result                res;
    bltd_pkg::t_result                oq_data;
    logic [CW-1:0]                    oq_count;
    logic [CW:0]                      in_flight;

    assign in_item.cmd               = bltd_pkg::t_cmd'(i_in.cmd);
    assign in_item.temp_sample       = i_in.temp_sample;
    assign in_item.backlight_switch  = i_in.backlight_switch;
    assign in_item.brightness_target = i_in.brightness_target;

    assign in_flight  = (CW+1)'(oq_count) + (CW+1)'(r_s1_valid);
    assign i_in.ready = (in_flight < (CW+1)'(OQ_DEPTH));
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= in_item;
        end
    end

    bltd_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept && in_item.cmd == bltd_pkg::CMD_SAMPLE),
        .i_wr     (ring_wr),
        .o_rd_idx (ring_idx),
        .o_old    (ring_old)
    );

    bltd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (r_s1_valid),
        .i_item     (r_s1_item),
        .i_idx      (ring_idx),
        .i_old      (ring_old),
        .o_wr       (ring_wr),
        .o_res      (res)
    );

    bltd_oq #(
        .DEPTH (OQ_DEPTH)
    ) u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (res),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (oq_data),
        .o_count (oq_count)
    );

    assign o_out.duty             = oq_data.duty;
    assign o_out.pwm_enabled      = oq_data.pwm_enabled;
    assign o_out.thermal_mode     = oq_data.thermal_mode;
    assign o_out.derating_active  = oq_data.derating_active;
    assign o_out.brightness_limit = oq_data.brightness_limit;
    assign o_out.derate_report    = oq_data.derate_report;
    assign o_out.brightness_now   = oq_data.brightness_now;

endmodule
`default_nettype wire

// ===== hw/rtl/bltd_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bltd_ring
// Sample ring RAM: read of the oldest entry on acceptance, write-back later.
// ----------------------------------------------------------------------------
module bltd_ring (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_rd_en,
    input  wire bltd_pkg::t_ring_wr                   i_wr,
    output logic     [bltd_pkg::RING_AW-1:0]          o_rd_idx,
    output logic     [bltd_pkg::SAMPLE_BITS-1:0]      o_old
);

    logic [bltd_pkg::SAMPLE_BITS-1:0] r_mem [bltd_pkg::AVG_DEPTH];
    logic [bltd_pkg::SAMPLE_BITS-1:0] r_rd_data;
    logic [bltd_pkg::RING_AW-1:0]     r_idx;
    logic [bltd_pkg::RING_AW-1:0]     r_rd_idx;
    logic                             r_wrapped;
    logic                             r_old_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_idx  <= r_idx;
        end
    end

    // entries not yet written read as zero until the index has wrapped once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_wrapped <= 1'b0;
            r_old_ok  <= 1'b0;
        end else if (i_rd_en) begin
            r_idx    <= r_idx + 1'b1;
            r_old_ok <= r_wrapped;
            if (r_idx == bltd_pkg::RING_AW'(bltd_pkg::AVG_DEPTH - 1)) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    assign o_rd_idx = r_rd_idx;
    assign o_old    = r_old_ok ? r_rd_data : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/bltd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bltd_ctrl
// Configuration registers, running sum, derating modes, dimming and duty.
// ----------------------------------------------------------------------------
module bltd_ctrl (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic    [bltd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic    [bltd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                                 i_valid,
    input  wire bltd_pkg::t_item                      i_item,
    input  wire logic    [bltd_pkg::RING_AW-1:0]      i_idx,
    input  wire logic    [bltd_pkg::SAMPLE_BITS-1:0]  i_old,
    output bltd_pkg::t_ring_wr                        o_wr,
    output bltd_pkg::t_result                         o_res
);

    logic [11:0] r_enter_burn;
    logic [11:0] r_enter_boil;
    logic [11:0] r_enter_scorch;
    logic [11:0] r_recover;
    logic [15:0] r_duty_unit;
    logic [15:0] r_duty_period;
    logic        r_batt_protect;
    logic [7:0]  r_recover_ticks;

    logic [bltd_pkg::SUM_W-1:0] r_sum, n_sum;
    logic                       r_full, n_full;
    bltd_pkg::t_mode            r_mode, n_mode;
    logic                       r_derate, n_derate;
    logic                       r_pending, n_pending;
    logic [6:0]                 r_limit, n_limit;
    logic [7:0]                 r_hold, n_hold;
    logic                       r_hold_run, n_hold_run;
    logic [6:0]                 r_bright, n_bright;
    logic [6:0]                 r_fade, n_fade;
    logic                       r_pwm, n_pwm;
    logic [15:0]                r_duty, n_duty;

    logic                             report;
    logic [bltd_pkg::SAMPLE_BITS-1:0] avg;
    logic [7:0]                       tgt8;
    logic [6:0]                       tgt;
    logic [6:0]                       fade_inc;
    logic [6:0]                       fade_use;
    logic [6:0]                       diff;
    logic [22:0]                      prod;

    function automatic logic [6:0] ramp(input logic [6:0] b, input logic [6:0] t);
        logic [6:0] res;
        res = b;
        if (b > t) begin
            res = ((b - t) < bltd_pkg::RAMP_STEP) ? t : b - bltd_pkg::RAMP_STEP;
        end else if (b < t) begin
            res = ((t - b) < bltd_pkg::RAMP_STEP) ? t : b + bltd_pkg::RAMP_STEP;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_burn    <= 12'd1800;
            r_enter_boil    <= 12'd1700;
            r_enter_scorch  <= 12'd1400;
            r_recover       <= 12'd2000;
            r_duty_unit     <= 16'd10;
            r_duty_period   <= 16'd1000;
            r_batt_protect  <= 1'b0;
            r_recover_ticks <= 8'd30;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bltd_pkg::REG_ENTER_BURN:   r_enter_burn    <= i_cfg_data[11:0];
                bltd_pkg::REG_ENTER_BOIL:   r_enter_boil    <= i_cfg_data[11:0];
                bltd_pkg::REG_ENTER_SCORCH: r_enter_scorch  <= i_cfg_data[11:0];
                bltd_pkg::REG_RECOVER:      r_recover       <= i_cfg_data[11:0];
                bltd_pkg::REG_DUTY_UNIT:    r_duty_unit     <= i_cfg_data;
                bltd_pkg::REG_DUTY_PERIOD:  r_duty_period   <= i_cfg_data;
                bltd_pkg::REG_BATT_PROTECT: r_batt_protect  <= i_cfg_data[0];
                bltd_pkg::REG_RECOVER_TICK: r_recover_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_sum      = r_sum;
        n_full     = r_full;
        n_mode     = r_mode;
        n_derate   = r_derate;
        n_pending  = r_pending;
        n_limit    = r_limit;
        n_hold     = r_hold;
        n_hold_run = r_hold_run;
        n_bright   = r_bright;
        n_fade     = r_fade;
        n_pwm      = r_pwm;
        n_duty     = r_duty;
        report     = 1'b0;
        avg        = '0;
        tgt8       = '0;
        tgt        = '0;
        fade_inc   = '0;
        fade_use   = '0;
        diff       = '0;
        prod       = '0;

        o_wr.en   = 1'b0;
        o_wr.addr = i_idx;
        o_wr.data = i_item.temp_sample;

        unique case (i_item.cmd)
            bltd_pkg::CMD_SAMPLE: begin
                o_wr.en = i_valid;
                n_sum   = r_sum - bltd_pkg::SUM_W'(i_old)
                               + bltd_pkg::SUM_W'(i_item.temp_sample);
                if (i_idx == bltd_pkg::RING_AW'(bltd_pkg::AVG_DEPTH - 1)) begin
                    n_full = 1'b1;
                end
                avg = n_sum[bltd_pkg::SUM_W-1 -: bltd_pkg::SAMPLE_BITS];
                if (n_full) begin
                    if (r_mode == bltd_pkg::MODE_NORMAL) begin
                        n_derate = 1'b0;
                        n_limit  = bltd_pkg::LIMIT_FULL;
                        if (avg < r_enter_burn) begin
                            n_derate  = 1'b1;
                            n_pending = 1'b1;
                            n_mode    = bltd_pkg::MODE_BURN;
                        end
                    end else begin
                        n_derate = 1'b1;
                        n_limit  = (r_mode == bltd_pkg::MODE_BURN) ?
                                   bltd_pkg::LIMIT_BURN : bltd_pkg::LIMIT_HOT;
                        priority if (avg > r_recover) begin
                            n_hold_run = 1'b1;
                            if (r_hold > r_recover_ticks) begin
                                n_hold_run = 1'b0;
                                n_hold     = '0;
                                n_derate   = 1'b0;
                                n_pending  = 1'b1;
                                n_mode     = bltd_pkg::MODE_NORMAL;
                            end
                        end else if (r_mode == bltd_pkg::MODE_BURN
                                     && avg < r_enter_boil) begin
                            n_pending = 1'b1;
                            n_mode    = bltd_pkg::MODE_BOIL;
                        end else if (r_mode == bltd_pkg::MODE_BOIL
                                     && avg < r_enter_scorch) begin
                            n_pending = 1'b1;
                            n_mode    = bltd_pkg::MODE_SCORCH;
                        end else begin
                            n_mode = r_mode;
                        end
                    end
                end
            end
            bltd_pkg::CMD_DIM: begin
                tgt8     = (i_item.brightness_target > {1'b0, r_limit}) ?
                           {1'b0, r_limit} : i_item.brightness_target;
                tgt      = tgt8[6:0];
                fade_inc = r_fade + bltd_pkg::RAMP_STEP;
                fade_use = (r_fade != tgt) ? ((fade_inc > tgt) ? tgt : fade_inc) : tgt;
                if (i_item.backlight_switch == bltd_pkg::SW_RAMP) begin
                    n_fade   = '0;
                    n_bright = ramp(r_bright, tgt);
                    n_pwm    = ~r_batt_protect;
                end else if (i_item.backlight_switch == bltd_pkg::SW_FADE) begin
                    n_fade   = fade_use;
                    n_bright = ramp(r_bright, tgt);
                    if (r_fade == tgt) begin
                        n_pwm = 1'b0;
                    end
                end
                if (i_item.backlight_switch == bltd_pkg::SW_RAMP
                    || i_item.backlight_switch == bltd_pkg::SW_FADE) begin
                    diff   = (n_bright >= n_fade) ? n_bright - n_fade : '0;
                    prod   = 23'(diff) * 23'(r_duty_unit);
                    n_duty = (prod > 23'(r_duty_period)) ? r_duty_period : prod[15:0];
                end
                report    = r_pending;
                n_pending = 1'b0;
            end
            bltd_pkg::CMD_TICK: begin
                if (r_hold_run && r_hold != 8'hFF) begin
                    n_hold = r_hold + 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_full     <= 1'b0;
            r_mode     <= bltd_pkg::MODE_NORMAL;
            r_derate   <= 1'b0;
            r_pending  <= 1'b0;
            r_limit    <= bltd_pkg::LIMIT_FULL;
            r_hold     <= '0;
            r_hold_run <= 1'b0;
            r_bright   <= '0;
            r_fade     <= '0;
            r_pwm      <= 1'b1;
            r_duty     <= '0;
        end else if (i_valid) begin
            r_sum      <= n_sum;
            r_full     <= n_full;
            r_mode     <= n_mode;
            r_derate   <= n_derate;
            r_pending  <= n_pending;
            r_limit    <= n_limit;
            r_hold     <= n_hold;
            r_hold_run <= n_hold_run;
            r_bright   <= n_bright;
            r_fade     <= n_fade;
            r_pwm      <= n_pwm;
            r_duty     <= n_duty;
        end
    end

    always_comb begin
        o_res.duty             = n_duty;
        o_res.pwm_enabled      = n_pwm;
        o_res.thermal_mode     = n_mode;
        o_res.derating_active  = n_derate;
        o_res.brightness_limit = n_limit;
        o_res.derate_report    = report;
        o_res.brightness_now   = n_bright;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bltd_oq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bltd_oq
// Output queue: holds finished results until the sink takes them.
// ----------------------------------------------------------------------------
module bltd_oq #(
    parameter int DEPTH = bltd_pkg::OQ_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire bltd_pkg::t_result           i_data,
    input  wire logic                        i_pop,
    output logic                             o_valid,
    output bltd_pkg::t_result                o_data,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bltd_pkg::t_result r_buf [DEPTH];
    logic [AW-1:0]     r_wptr, r_rptr;
    logic [CW-1:0]     r_count;
    logic              pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= wrap_inc(r_wptr);
            end
            if (pop_ok) begin
                r_rptr <= wrap_inc(r_rptr);
            end
            r_count <= r_count + CW'(i_push) - CW'(pop_ok);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rptr];
    assign o_count = r_count;

endmodule
`default_nettype wire

// ===== sim/tb_backlight_thermal_derate_dimmer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_backlight_thermal_derate_dimmer
// Self-checking bench for the backlight dimmer with thermal derating.
// A short table of hand-picked items runs first. Its reset, extreme, first
// ramp step and fade-out rows carry their expected status written out, and
// every other row is checked against a behavioural model of the ring average,
// the mode machine, the ramp and fade logic and the duty clamp. Five register
// settings follow, from the reset values over both extremes to random
// thresholds. Each setting runs random temperature segments that cross the
// mode thresholds, together with dimming updates and ticks. The sender
// works in bursts and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_backlight_thermal_derate_dimmer;
    import bltd_pkg::*;

    localparam int PHASE_ITEMS = 385;
    localparam int N_PHASES    = 5;
    localparam int DIR_N       = 25;

    typedef struct {
        t_cmd        cmd;
        logic [11:0] smp;
        logic [7:0]  sw;
        logic [7:0]  tgt;
        bit          typed;
        t_result     want;
    } t_dir_row;

    localparam t_result IDLE_STATUS = '{duty: 16'd0, pwm_enabled: 1'b1,
        thermal_mode: MODE_NORMAL, derating_active: 1'b0,
        brightness_limit: LIMIT_FULL, derate_report: 1'b0, brightness_now: 7'd0};
    localparam t_result FIRST_STEP = '{duty: 16'd40, pwm_enabled: 1'b1,
        thermal_mode: MODE_NORMAL, derating_active: 1'b0,
        brightness_limit: LIMIT_FULL, derate_report: 1'b0, brightness_now: 7'd4};
    localparam t_result FADED_OUT = '{duty: 16'd0, pwm_enabled: 1'b0,
        thermal_mode: MODE_NORMAL, derating_active: 1'b0,
        brightness_limit: LIMIT_FULL, derate_report: 1'b0, brightness_now: 7'd0};

    t_dir_row dir_rows [DIR_N] = '{
        '{CMD_TICK,   12'h000, 8'h00,   8'h00,   1'b1, IDLE_STATUS},
        '{CMD_NONE,   12'hfff, 8'hff,   8'hff,   1'b1, IDLE_STATUS},
        '{CMD_SAMPLE, 12'hfff, 8'h00,   8'h00,   1'b1, IDLE_STATUS},
        '{CMD_SAMPLE, 12'h000, 8'hff,   8'hff,   1'b1, IDLE_STATUS},
        '{CMD_DIM,    12'h000, 8'h00,   8'hff,   1'b1, IDLE_STATUS},
        '{CMD_DIM,    12'hfff, 8'hff,   8'h00,   1'b1, IDLE_STATUS},
        '{CMD_DIM,    12'h000, SW_RAMP, 8'hff,   1'b1, FIRST_STEP},
        '{CMD_DIM,    12'h000, SW_RAMP, 8'hff,   1'b0, '0},
        '{CMD_DIM,    12'h000, SW_RAMP, 8'd2,    1'b0, '0},
        '{CMD_DIM,    12'h000, SW_RAMP, 8'd0,    1'b0, '0},
        '{CMD_DIM,    12'h000, SW_RAMP, 8'd0,    1'b0, '0},
        '{CMD_DIM,    12'h000, SW_FADE, 8'd0,    1'b1, FADED_OUT},
        '{CMD_DIM,    12'h000, SW_FADE, 8'd50,   1'b0, '0},
        '{CMD_DIM,    12'h000, SW_RAMP, 8'd100,  1'b0, '0},
        '{CMD_DIM,    12'h000, SW_RAMP, 8'd100,  1'b0, '0},
        '{CMD_DIM,    12'h000, SW_FADE, 8'd10,   1'b0, '0},
        '{CMD_DIM,    12'h000, SW_FADE, 8'd10,   1'b0, '0},
        '{CMD_DIM,    12'h000, SW_FADE, 8'd10,   1'b0, '0},
        '{CMD_DIM,    12'h000, SW_FADE, 8'd10,   1'b0, '0},
        '{CMD_DIM,    12'h000, SW_FADE, 8'd255,  1'b0, '0},
        '{CMD_DIM,    12'h000, 8'h80,   8'h7f,   1'b0, '0},
        '{CMD_DIM,    12'h000, 8'h03,   8'd1,    1'b0, '0},
        '{CMD_TICK,   12'hfff, 8'hff,   8'hff,   1'b0, '0},
        '{CMD_SAMPLE, 12'h800, 8'h00,   8'h00,   1'b0, '0},
        '{CMD_DIM,    12'h000, SW_RAMP, 8'd255,  1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bltd_in_if  in_if ();
    bltd_out_if out_if ();

    backlight_thermal_derate_dimmer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // model state and register copy
    logic [11:0] ring_mem [AVG_DEPTH];
    int unsigned ring_ptr, running_sum, limit_pct, hold_cnt, bright, fade, duty_now;
    bit          ring_filled, derating, report_due, holding, pwm_on;
    t_mode       cur_mode;
    int unsigned cfg_burn, cfg_boil, cfg_scorch, cfg_recover;
    int unsigned cfg_unit, cfg_period, cfg_batt, cfg_ticks;

    t_result pending_status [$];
    t_result want_st;
    int      fail_count, status_checked, reports_seen, sent_count, returns_to_normal;
    int      deepest_mode;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void ramp_brightness(int unsigned tgt, int unsigned fd);
        int unsigned d;
        if (bright > tgt) begin
            bright = (bright - tgt < RAMP_STEP) ? tgt : bright - RAMP_STEP;
        end else if (bright < tgt) begin
            bright = (tgt - bright < RAMP_STEP) ? tgt : bright + RAMP_STEP;
        end
        bright = bright & 'h7f;
        d = (bright >= fd) ? (bright - fd) * cfg_unit : 0;
        if (d > cfg_period) d = cfg_period;
        duty_now = d & 'hffff;
    endfunction

    function automatic t_result predict_status(t_item it);
        t_result     r;
        int unsigned avg, tgt;
        t_mode       nxt;
        bit          popped;
        popped = 1'b0;
        case (it.cmd)
            CMD_SAMPLE: begin
                running_sum = running_sum - ring_mem[ring_ptr] + it.temp_sample;
                ring_mem[ring_ptr] = it.temp_sample;
                if (ring_ptr == AVG_DEPTH - 1) ring_filled = 1'b1;
                ring_ptr = (ring_ptr + 1) % AVG_DEPTH;
                if (ring_filled) begin
                    avg = running_sum >> 4;
                    nxt = cur_mode;
                    if (cur_mode == MODE_NORMAL) begin
                        derating  = 1'b0;
                        limit_pct = LIMIT_FULL;
                        if (avg < cfg_burn) begin
                            derating   = 1'b1;
                            report_due = 1'b1;
                            nxt        = MODE_BURN;
                        end
                    end else begin
                        derating  = 1'b1;
                        limit_pct = (cur_mode == MODE_BURN) ? LIMIT_BURN : LIMIT_HOT;
                        if (avg > cfg_recover) begin
                            holding = 1'b1;
                            if (hold_cnt > cfg_ticks) begin
                                holding    = 1'b0;
                                hold_cnt   = 0;
                                derating   = 1'b0;
                                report_due = 1'b1;
                                nxt        = MODE_NORMAL;
                                returns_to_normal++;
                            end
                        end else if (cur_mode == MODE_BURN && avg < cfg_boil) begin
                            report_due = 1'b1;
                            nxt        = MODE_BOIL;
                        end else if (cur_mode == MODE_BOIL && avg < cfg_scorch) begin
                            report_due = 1'b1;
                            nxt        = MODE_SCORCH;
                        end
                    end
                    cur_mode = nxt;
                end
            end
            CMD_DIM: begin
                tgt = it.brightness_target;
                if (tgt > limit_pct) tgt = limit_pct;
                if (it.backlight_switch == SW_RAMP) begin
                    fade = 0;
                    ramp_brightness(tgt, 0);
                    pwm_on = (cfg_batt == 0);
                end else if (it.backlight_switch == SW_FADE) begin
                    if (fade != tgt) begin
                        fade = (fade + RAMP_STEP) & 'h7f;
                        if (fade > tgt) fade = tgt;
                        ramp_brightness(tgt, fade);
                    end else begin
                        ramp_brightness(tgt, tgt);
                        pwm_on = 1'b0;
                    end
                end
                if (report_due) begin
                    report_due = 1'b0;
                    popped     = 1'b1;
                end
            end
            CMD_TICK: begin
                if (holding && hold_cnt < 255) hold_cnt++;
            end
            default: ;
        endcase
        r.duty             = duty_now[15:0];
        r.pwm_enabled      = pwm_on;
        r.thermal_mode     = cur_mode;
        r.derating_active  = derating;
        r.brightness_limit = limit_pct[6:0];
        r.derate_report    = popped;
        r.brightness_now   = bright[6:0];
        return r;
    endfunction

    task automatic push_item(input t_item it, input bit typed, input t_result want);
        t_result r;
        @(negedge clk);
        in_if.valid             <= 1'b1;
        in_if.cmd               <= it.cmd;
        in_if.temp_sample       <= it.temp_sample;
        in_if.backlight_switch  <= it.backlight_switch;
        in_if.brightness_target <= it.brightness_target;
        do @(posedge clk); while (!in_if.ready);
        r = predict_status(it);
        pending_status.push_back(typed ? want : r);
        sent_count++;
    endtask

    task automatic settle_results();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[15:0];
        case (idx)
            REG_ENTER_BURN:   cfg_burn    = val & 'hfff;
            REG_ENTER_BOIL:   cfg_boil    = val & 'hfff;
            REG_ENTER_SCORCH: cfg_scorch  = val & 'hfff;
            REG_RECOVER:      cfg_recover = val & 'hfff;
            REG_DUTY_UNIT:    cfg_unit    = val & 'hffff;
            REG_DUTY_PERIOD:  cfg_period  = val & 'hffff;
            REG_BATT_PROTECT: cfg_batt    = val & 1;
            REG_RECOVER_TICK: cfg_ticks   = val & 'hff;
            default: ;
        endcase
    endtask

    task automatic run_phase(input int n_items);
        t_item       it;
        int unsigned burst, seg_left, tick_pct, r;
        int          level, smp;
        seg_left = 0;
        tick_pct = 5;
        level    = 2048;
        burst    = $urandom_range(1, 24);
        for (int k = 0; k < n_items; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(30, 150);
                case ($urandom_range(0, 2))
                    0:       tick_pct = 5;
                    1:       tick_pct = 15;
                    default: tick_pct = 45;
                endcase
                case ($urandom_range(0, 6))
                    0:       level = int'(cfg_burn);
                    1:       level = int'(cfg_boil);
                    2:       level = int'(cfg_scorch);
                    3:       level = int'(cfg_recover) + 150;
                    4:       level = int'(cfg_recover) + 600;
                    5:       level = int'(cfg_scorch) - 400;
                    default: level = int'($urandom_range(0, 4095));
                endcase
                level = level + int'($urandom_range(0, 120)) - 60;
            end
            seg_left--;
            // hold off once mid-phase until every status has come back
            if (k == n_items / 2) settle_results();
            it.temp_sample       = $urandom_range(0, 4095);
            it.backlight_switch  = $urandom_range(0, 255);
            it.brightness_target = $urandom_range(0, 255);
            r = $urandom_range(0, 99);
            if (r < tick_pct) begin
                it.cmd = CMD_TICK;
            end else if (r < tick_pct + 3) begin
                it.cmd = CMD_NONE;
            end else if ($urandom_range(0, 99) < 55) begin
                it.cmd = CMD_SAMPLE;
                if ($urandom_range(0, 7) != 0) begin
                    smp = level + int'($urandom_range(0, 80)) - 40;
                    if (smp < 0) smp = 0;
                    if (smp > 4095) smp = 4095;
                    it.temp_sample = smp[11:0];
                end
            end else begin
                it.cmd = CMD_DIM;
                r = $urandom_range(0, 9);
                if (r < 4) it.backlight_switch = SW_RAMP;
                else if (r < 8) it.backlight_switch = SW_FADE;
                if ($urandom_range(0, 3) != 0) it.brightness_target = $urandom_range(0, 110);
            end
            push_item(it, 1'b0, '0);
            burst--;
            if (burst == 0) begin
                repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6)) begin
                    @(negedge clk);
                    in_if.valid <= 1'b0;
                end
                burst = $urandom_range(1, 24);
            end
        end
    endtask

    // receiver stall patterns
    initial begin
        int unsigned style, cyc;
        out_if.ready = 1'b0;
        cyc = 0;
        forever begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(negedge clk);
                cyc++;
                case (style)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_if.ready <= ((cyc % 11) > 6);
                    default: out_if.ready <= cyc[0];
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_status.size() == 0) begin
                $error("status transaction with no expectation waiting");
                fail_count++;
            end else begin
                want_st = pending_status.pop_front();
                status_checked++;
                if (out_if.derate_report) reports_seen++;
                if (int'(out_if.thermal_mode) > deepest_mode)
                    deepest_mode = out_if.thermal_mode;
                if (out_if.duty !== want_st.duty) begin
                    $error("duty: expected %0d, got %0d", want_st.duty, out_if.duty);
                    fail_count++;
                end
                if (out_if.pwm_enabled !== want_st.pwm_enabled) begin
                    $error("pwm_enabled: expected %0d, got %0d",
                           want_st.pwm_enabled, out_if.pwm_enabled);
                    fail_count++;
                end
                if (out_if.thermal_mode !== want_st.thermal_mode) begin
                    $error("thermal_mode: expected %0d, got %0d",
                           want_st.thermal_mode, out_if.thermal_mode);
                    fail_count++;
                end
                if (out_if.derating_active !== want_st.derating_active) begin
                    $error("derating_active: expected %0d, got %0d",
                           want_st.derating_active, out_if.derating_active);
                    fail_count++;
                end
                if (out_if.brightness_limit !== want_st.brightness_limit) begin
                    $error("brightness_limit: expected %0d, got %0d",
                           want_st.brightness_limit, out_if.brightness_limit);
                    fail_count++;
                end
                if (out_if.derate_report !== want_st.derate_report) begin
                    $error("derate_report: expected %0d, got %0d",
                           want_st.derate_report, out_if.derate_report);
                    fail_count++;
                end
                if (out_if.brightness_now !== want_st.brightness_now) begin
                    $error("brightness_now: expected %0d, got %0d",
                           want_st.brightness_now, out_if.brightness_now);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int unsigned settings [8];
        int          waited;
        t_item       it;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = '0;
        cfg_data                = '0;
        in_if.valid             = 1'b0;
        in_if.cmd               = CMD_NONE;
        in_if.temp_sample       = '0;
        in_if.backlight_switch  = '0;
        in_if.brightness_target = '0;

        foreach (ring_mem[i]) ring_mem[i] = '0;
        ring_ptr    = 0;
        running_sum = 0;
        ring_filled = 1'b0;
        cur_mode    = MODE_NORMAL;
        derating    = 1'b0;
        report_due  = 1'b0;
        limit_pct   = LIMIT_FULL;
        hold_cnt    = 0;
        holding     = 1'b0;
        bright      = 0;
        fade        = 0;
        pwm_on      = 1'b1;
        duty_now    = 0;
        cfg_burn    = 1800;
        cfg_boil    = 1700;
        cfg_scorch  = 1400;
        cfg_recover = 2000;
        cfg_unit    = 10;
        cfg_period  = 1000;
        cfg_batt    = 0;
        cfg_ticks   = 30;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            it.cmd               = dir_rows[i].cmd;
            it.temp_sample       = dir_rows[i].smp;
            it.backlight_switch  = dir_rows[i].sw;
            it.brightness_target = dir_rows[i].tgt;
            push_item(it, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle_results();
            case (p)
                0: begin
                    settings[REG_ENTER_BURN]   = 1800;
                    settings[REG_ENTER_BOIL]   = 1700;
                    settings[REG_ENTER_SCORCH] = 1400;
                    settings[REG_RECOVER]      = 2000;
                    settings[REG_DUTY_UNIT]    = 10;
                    settings[REG_DUTY_PERIOD]  = 1000;
                    settings[REG_BATT_PROTECT] = 0;
                    settings[REG_RECOVER_TICK] = 30;
                end
                1: begin
                    settings[REG_ENTER_BURN]   = 4095;
                    settings[REG_ENTER_BOIL]   = 4095;
                    settings[REG_ENTER_SCORCH] = 4095;
                    settings[REG_RECOVER]      = 4095;
                    settings[REG_DUTY_UNIT]    = 65535;
                    settings[REG_DUTY_PERIOD]  = 65535;
                    settings[REG_BATT_PROTECT] = 1;
                    settings[REG_RECOVER_TICK] = 255;
                end
                2: begin
                    foreach (settings[i]) settings[i] = 0;
                end
                default: begin
                    settings[REG_RECOVER]      = $urandom_range(1500, 3200);
                    settings[REG_ENTER_BURN]   = settings[REG_RECOVER]
                                                 - $urandom_range(0, 400);
                    settings[REG_ENTER_BOIL]   = settings[REG_ENTER_BURN]
                                                 - $urandom_range(0, 300);
                    settings[REG_ENTER_SCORCH] = settings[REG_ENTER_BOIL]
                                                 - $urandom_range(0, 400);
                    settings[REG_DUTY_UNIT]    = $urandom_range(1, 1500);
                    settings[REG_DUTY_PERIOD]  = $urandom_range(0, 65535);
                    settings[REG_BATT_PROTECT] = $urandom_range(0, 1);
                    settings[REG_RECOVER_TICK] = $urandom_range(0, 12);
                end
            endcase
            for (int r = 0; r < 8; r++) write_reg(r[CFG_IDX_W-1:0], settings[r]);
            @(negedge clk);
            cfg_we <= 1'b0;
            run_phase(PHASE_ITEMS);
        end

        @(negedge clk);
        in_if.valid <= 1'b0;
        waited = 0;
        while (pending_status.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        if (pending_status.size() != 0) begin
            $error("%0d status transactions never arrived", pending_status.size());
            fail_count++;
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d transactions under %0d register settings, %0d status results checked.",
                 sent_count, N_PHASES, status_checked);
        $display("Saw %0d derate reports, %0d returns to normal, deepest mode %0d.",
                 reports_seen, returns_to_normal, deepest_mode);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
